/* hw/rtl/rpbk_pkg.sv */
// ----------------------------------------------------------------------------
// rpbk_pkg
// Types and constants shared by the RGB blend-with-key pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rpbk_pkg;

	localparam int unsigned ChanW   = 8;
	localparam int unsigned NumChan = 3;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgW    = 8;

	// one byte per channel, index 0 = red (lowest bits)
	typedef logic [NumChan-1:0][ChanW-1:0] chan_t;
	typedef logic [NumChan-1:0][ChanW:0]   wide_t;
	typedef logic [NumChan-1:0]            flag_t;

	typedef enum logic [2:0] {
		MODE_OFF = 3'd0,
		MODE_AVG = 3'd1,
		MODE_ADD = 3'd2,
		MODE_SUB = 3'd3,
		MODE_OVR = 3'd4
	} blend_mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_BLEND_MODE   = 3'd0,
		CFG_BACK_ENABLE  = 3'd1,
		CFG_BACK_LOW     = 3'd2,
		CFG_BACK_HIGH    = 3'd3,
		CFG_OVERLAY_LOW  = 3'd4,
		CFG_OVERLAY_HIGH = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [2:0]       blend_mode;
		logic             back_enable;
		logic [ChanW-1:0] back_low;
		logic [ChanW-1:0] back_high;
		logic [ChanW-1:0] overlay_low;
		logic [ChanW-1:0] overlay_high;
	} cfg_t;

	localparam logic [ChanW-1:0] ChanMax = '1;
	localparam logic [ChanW-1:0] ChanMin = '0;

endpackage

`default_nettype wire

/* hw/rtl/rgb_pixel_blend_with_key_top.sv */
// ----------------------------------------------------------------------------
// rgb_pixel_blend_with_key_top
// RGB pixel blender with background range keying, three-stage pipeline.
//
//   channel  dir  width  contents
//   s_axis   in   72     dest rgb, src rgb, back rgb (see s_tdata)
//   m_axis   out  24     out rgb
//   cfg      in   3+8    register index, write data
//
// One beat per clock sustained unless m_tready stalls; beats pass the key,
// arith and mode registers to m_tvalid. Each stage holds a valid bit and
// stalls only when full and the next stage cannot take its beat, so bubbles
// collapse. Reset clears valid bits and loads defaults (overlay_high = 255).
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_pixel_blend_with_key_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// dest_red, dest_green, dest_blue, src_red, src_green, src_blue,
	// back_red, back_green, back_blue (8 bits each, lowest first)
	input  wire logic [71:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_red, out_green, out_blue (8 bits each, lowest first)
	output logic [23:0]      m_tdata
);
	import rpbk_pkg::*;

	cfg_t  cfg_q;
	chan_t dest_s1, src_s1, dest_s2, src_s2, pix_s3;
	flag_t hit_s1, hit_s2;
	wide_t sum_s2, diff_s2;
	logic  v1, r1, v2, r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blend_mode   <= MODE_OFF;
			cfg_q.back_enable  <= 1'b0;
			cfg_q.back_low     <= ChanMin;
			cfg_q.back_high    <= ChanMin;
			cfg_q.overlay_low  <= ChanMin;
			cfg_q.overlay_high <= ChanMax;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_BLEND_MODE:   cfg_q.blend_mode   <= cfg_data[2:0];
				CFG_BACK_ENABLE:  cfg_q.back_enable  <= cfg_data[0];
				CFG_BACK_LOW:     cfg_q.back_low     <= cfg_data;
				CFG_BACK_HIGH:    cfg_q.back_high    <= cfg_data;
				CFG_OVERLAY_LOW:  cfg_q.overlay_low  <= cfg_data;
				CFG_OVERLAY_HIGH: cfg_q.overlay_high <= cfg_data;
				default: ;
			endcase
		end
	end

	rpbk_key u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_dest   (s_tdata[23:0]),
		.in_src    (s_tdata[47:24]),
		.in_back   (s_tdata[71:48]),
		.out_valid (v1),
		.out_ready (r1),
		.dest_s1   (dest_s1),
		.src_s1    (src_s1),
		.hit_s1    (hit_s1)
	);

	rpbk_arith u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_dest   (dest_s1),
		.in_src    (src_s1),
		.in_hit    (hit_s1),
		.out_valid (v2),
		.out_ready (r2),
		.dest_s2   (dest_s2),
		.src_s2    (src_s2),
		.hit_s2    (hit_s2),
		.sum_s2    (sum_s2),
		.diff_s2   (diff_s2)
	);

	rpbk_mode u_mode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (v2),
		.in_ready  (r2),
		.in_dest   (dest_s2),
		.in_src    (src_s2),
		.in_hit    (hit_s2),
		.in_sum    (sum_s2),
		.in_diff   (diff_s2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.pix_s3    (pix_s3)
	);

	assign m_tdata = pix_s3;

endmodule

`default_nettype wire

/* hw/rtl/rpbk_key.sv */
// ----------------------------------------------------------------------------
// rpbk_key
// Stage 1: background range keying of the destination and overlay range test.
// ----------------------------------------------------------------------------
`default_nettype none

module rpbk_key (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rpbk_pkg::cfg_t cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire rpbk_pkg::chan_t in_dest,
	input  wire rpbk_pkg::chan_t in_src,
	input  wire rpbk_pkg::chan_t in_back,
	output logic                out_valid,
	input  wire logic           out_ready,
	output rpbk_pkg::chan_t     dest_s1,
	output rpbk_pkg::chan_t     src_s1,
	output rpbk_pkg::flag_t     hit_s1
);
	import rpbk_pkg::*;

	logic  valid_s1;
	chan_t dest_keyed;
	flag_t hit;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			dest_keyed[c] = (cfg.back_enable && in_dest[c] >= cfg.back_low &&
				in_dest[c] <= cfg.back_high) ? in_back[c] : in_dest[c];
			hit[c] = in_src[c] >= cfg.overlay_low && in_src[c] <= cfg.overlay_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dest_s1 <= dest_keyed;
			src_s1  <= in_src;
			hit_s1  <= hit;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/rpbk_arith.sv */
// ----------------------------------------------------------------------------
// rpbk_arith
// Stage 2: per-channel 9-bit sum and difference of keyed destination and source.
// ----------------------------------------------------------------------------
`default_nettype none

module rpbk_arith (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire rpbk_pkg::chan_t in_dest,
	input  wire rpbk_pkg::chan_t in_src,
	input  wire rpbk_pkg::flag_t in_hit,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output rpbk_pkg::chan_t      dest_s2,
	output rpbk_pkg::chan_t      src_s2,
	output rpbk_pkg::flag_t      hit_s2,
	output rpbk_pkg::wide_t      sum_s2,
	output rpbk_pkg::wide_t      diff_s2
);
	import rpbk_pkg::*;

	logic  valid_s2;
	wide_t sum;
	wide_t diff;

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			sum[c]  = {1'b0, in_dest[c]} + {1'b0, in_src[c]};
			diff[c] = {1'b0, in_dest[c]} - {1'b0, in_src[c]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dest_s2 <= in_dest;
			src_s2  <= in_src;
			hit_s2  <= in_hit;
			sum_s2  <= sum;
			diff_s2 <= diff;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/rpbk_mode.sv */
// ----------------------------------------------------------------------------
// rpbk_mode
// Stage 3: blend mode select with saturation, feeding the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpbk_mode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rpbk_pkg::cfg_t  cfg,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire rpbk_pkg::chan_t in_dest,
	input  wire rpbk_pkg::chan_t in_src,
	input  wire rpbk_pkg::flag_t in_hit,
	input  wire rpbk_pkg::wide_t in_sum,
	input  wire rpbk_pkg::wide_t in_diff,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output rpbk_pkg::chan_t      pix_s3
);
	import rpbk_pkg::*;

	logic  valid_s3;
	chan_t pix;

	assign in_ready  = !valid_s3 || out_ready;
	assign out_valid = valid_s3;

	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			case (blend_mode_t'(cfg.blend_mode))
				MODE_AVG: pix[c] = in_sum[c][ChanW:1];
				MODE_ADD: pix[c] = in_sum[c][ChanW] ? ChanMax : in_sum[c][ChanW-1:0];
				MODE_SUB: pix[c] = in_diff[c][ChanW] ? ChanMin : in_diff[c][ChanW-1:0];
				MODE_OVR: pix[c] = in_hit[c] ? in_src[c] : in_dest[c];
				default:  pix[c] = in_dest[c];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pix_s3 <= pix;
		end
	end

endmodule

`default_nettype wire
